// ===== src/nearest_neighbor_downscale_gray_macros.svh =====
// Assertion macros used by the downscaler top-level RTL.
// Needs signals named clk and rst_n in the including scope.
`ifndef NEAREST_NEIGHBOR_DOWNSCALE_GRAY_MACROS_SVH
`define NEAREST_NEIGHBOR_DOWNSCALE_GRAY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NDG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// The consequent must hold in the cycle after the antecedent.
`define NDG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

// ===== src/ndg_pkg.sv =====
// Shared types, constants and luma tables for the nearest-neighbour downscaler.
// Has no dependencies.
package ndg_pkg;

    localparam int MAX_DIM_DEF = 2048;
    localparam int CFG_W       = 12;
    localparam int IDX_W       = 3;
    localparam int PIX_W       = 16;
    localparam int POS_W       = 11;
    localparam int LUMA_W      = 8;
    localparam int TDATA_W     = 40;
    localparam int PAD_W       = TDATA_W - 2 * POS_W - PIX_W;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 12'd320;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 12'd240;
    localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 12'd240;
    localparam logic [CFG_W-1:0] DST_HEIGHT_RST = 12'd240;
    localparam logic             GRAY_MODE_RST  = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_GRAY_MODE  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
        logic [PIX_W-1:0] pixel;
    } sel_item_t;

    localparam int LUMA_R_WEIGHT = 77;
    localparam int LUMA_G_WEIGHT = 150;
    localparam int LUMA_B_WEIGHT = 29;

    typedef logic [15:0] lut32_t [0:31];
    typedef logic [15:0] lut64_t [0:63];

    // Weighted 8-bit expansion of a 5-bit channel.
    function automatic lut32_t build_lut5(input int weight);
        lut32_t t;
        for (int i = 0; i < 32; i++)
        begin
            t[i] = 16'(weight * ((i * 255) / 31));
        end
        return t;
    endfunction

    // Weighted 8-bit expansion of a 6-bit channel.
    function automatic lut64_t build_lut6(input int weight);
        lut64_t t;
        for (int i = 0; i < 64; i++)
        begin
            t[i] = 16'(weight * ((i * 255) / 63));
        end
        return t;
    endfunction

    localparam lut32_t RED_LUT   = build_lut5(LUMA_R_WEIGHT);
    localparam lut64_t GREEN_LUT = build_lut6(LUMA_G_WEIGHT);
    localparam lut32_t BLUE_LUT  = build_lut5(LUMA_B_WEIGHT);

endpackage

// ===== src/ndg_pos.sv =====
// Position tracker and pixel selection stage of the downscaler.
// Depends on ndg_pkg.
module ndg_pos
    import ndg_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [PIX_W-1:0]               pixel,
    input  logic                           frame_start,
    input  logic [$clog2(MAX_DIM+1)-1:0]   sw,
    input  logic [$clog2(MAX_DIM+1)-1:0]   sh,
    input  logic [$clog2(MAX_DIM+1)-1:0]   dw,
    input  logic [$clog2(MAX_DIM+1)-1:0]   dh,
    input  logic                           adv,
    output logic                           sel_valid,
    output sel_item_t                      sel_item
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int SUM_W = 2 * DIM_W;

    logic [CNT_W-1:0] src_col_reg, src_col_next;
    logic [CNT_W-1:0] src_row_reg, src_row_next;
    logic [DIM_W-1:0] dst_col_reg, dst_col_next;
    logic [DIM_W-1:0] dst_row_reg, dst_row_next;
    logic [SUM_W-1:0] col_tgt_reg, col_tgt_next;
    logic [SUM_W-1:0] col_pos_reg, col_pos_next;
    logic [SUM_W-1:0] row_tgt_reg, row_tgt_next;
    logic [SUM_W-1:0] row_pos_reg, row_pos_next;
    logic             row_chosen_reg, row_chosen_next;
    logic             sel_valid_reg, sel_valid_next;
    sel_item_t        sel_reg, sel_next;

    logic [CNT_W-1:0] eff_sc, eff_sr;
    logic [DIM_W-1:0] eff_dc, eff_dr, dr_adv;
    logic [SUM_W-1:0] eff_cts, eff_cps, eff_rts, eff_rps, rts_adv, rps_adv;
    logic             eff_rc, col_sel, row_live, emit, is_last, row_end, frame_end;
    logic             rc_adv;

    // A frame start puts every position back to its reset value first.
    assign eff_sc  = frame_start ? '0 : src_col_reg;
    assign eff_sr  = frame_start ? '0 : src_row_reg;
    assign eff_dc  = frame_start ? '0 : dst_col_reg;
    assign eff_dr  = frame_start ? '0 : dst_row_reg;
    assign eff_cts = frame_start ? '0 : col_tgt_reg;
    assign eff_cps = frame_start ? '0 : col_pos_reg;
    assign eff_rts = frame_start ? '0 : row_tgt_reg;
    assign eff_rps = frame_start ? '0 : row_pos_reg;
    assign eff_rc  = frame_start ? 1'b1 : row_chosen_reg;

    assign col_sel  = (eff_dc < dw) && (eff_cps <= eff_cts)
                      && (eff_cts < eff_cps + SUM_W'(dw));
    assign row_live = eff_rc && (eff_dr < dh);
    assign emit     = col_sel && row_live;
    assign is_last  = (eff_dc == dw - DIM_W'(1)) && (eff_dr == dh - DIM_W'(1));

    assign row_end   = DIM_W'(eff_sc) >= sw - DIM_W'(1);
    assign frame_end = DIM_W'(eff_sr) >= sh - DIM_W'(1);

    assign dr_adv  = row_live ? eff_dr + DIM_W'(1) : eff_dr;
    assign rts_adv = row_live ? eff_rts + SUM_W'(sh) : eff_rts;
    assign rps_adv = eff_rps + SUM_W'(dh);
    assign rc_adv  = (dr_adv < dh) && (rps_adv <= rts_adv)
                     && (rts_adv < rps_adv + SUM_W'(dh));

    always_comb
    begin
        src_col_next    = src_col_reg;
        src_row_next    = src_row_reg;
        dst_col_next    = dst_col_reg;
        dst_row_next    = dst_row_reg;
        col_tgt_next    = col_tgt_reg;
        col_pos_next    = col_pos_reg;
        row_tgt_next    = row_tgt_reg;
        row_pos_next    = row_pos_reg;
        row_chosen_next = row_chosen_reg;
        sel_valid_next  = sel_valid_reg;
        sel_next        = sel_reg;
        if (accept)
        begin
            sel_valid_next = emit;
            sel_next.x     = POS_W'(eff_dc);
            sel_next.y     = POS_W'(eff_dr);
            sel_next.last  = is_last;
            sel_next.pixel = pixel;
            if (row_end)
            begin
                src_col_next = '0;
                dst_col_next = '0;
                col_tgt_next = '0;
                col_pos_next = '0;
                if (frame_end)
                begin
                    src_row_next    = '0;
                    dst_row_next    = '0;
                    row_tgt_next    = '0;
                    row_pos_next    = '0;
                    row_chosen_next = 1'b1;
                end
                else
                begin
                    src_row_next    = eff_sr + CNT_W'(1);
                    dst_row_next    = dr_adv;
                    row_tgt_next    = rts_adv;
                    row_pos_next    = rps_adv;
                    row_chosen_next = rc_adv;
                end
            end
            else
            begin
                src_col_next    = eff_sc + CNT_W'(1);
                col_pos_next    = eff_cps + SUM_W'(dw);
                dst_col_next    = col_sel ? eff_dc + DIM_W'(1) : eff_dc;
                col_tgt_next    = col_sel ? eff_cts + SUM_W'(sw) : eff_cts;
                src_row_next    = eff_sr;
                dst_row_next    = eff_dr;
                row_tgt_next    = eff_rts;
                row_pos_next    = eff_rps;
                row_chosen_next = eff_rc;
            end
        end
        else if (adv)
        begin
            sel_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            dst_col_reg    <= '0;
            dst_row_reg    <= '0;
            col_tgt_reg    <= '0;
            col_pos_reg    <= '0;
            row_tgt_reg    <= '0;
            row_pos_reg    <= '0;
            row_chosen_reg <= 1'b1;
            sel_valid_reg  <= 1'b0;
        end
        else
        begin
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            dst_col_reg    <= dst_col_next;
            dst_row_reg    <= dst_row_next;
            col_tgt_reg    <= col_tgt_next;
            col_pos_reg    <= col_pos_next;
            row_tgt_reg    <= row_tgt_next;
            row_pos_reg    <= row_pos_next;
            row_chosen_reg <= row_chosen_next;
            sel_valid_reg  <= sel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

    assign sel_valid = sel_valid_reg;
    assign sel_item  = sel_reg;

endmodule

// ===== src/ndg_luma.sv =====
// Output stage of the downscaler: optional RGB565 to luma conversion and result register.
// Depends on ndg_pkg.
module ndg_luma
    import ndg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sel_valid,
    input  sel_item_t          sel_item,
    input  logic               gray_mode,
    input  logic               m_tready,
    output logic               adv,
    output logic               m_tvalid,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic [4:0]         red;
    logic [5:0]         green;
    logic [4:0]         blue;
    logic [16:0]        luma_sum;
    logic [PIX_W-1:0]   pixel_out;

    assign red   = sel_item.pixel[15:11];
    assign green = sel_item.pixel[10:5];
    assign blue  = sel_item.pixel[4:0];

    assign luma_sum  = 17'(RED_LUT[red]) + 17'(GREEN_LUT[green]) + 17'(BLUE_LUT[blue]);
    assign pixel_out = gray_mode ? PIX_W'(luma_sum[15:8]) : sel_item.pixel;

    assign adv = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = sel_valid;
            out_data_next  = {{PAD_W{1'b0}}, pixel_out, sel_item.y, sel_item.x};
            out_last_next  = sel_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/nearest_neighbor_downscale_gray.sv =====
// Nearest-neighbour downscaler for an RGB565 raster stream, with optional 8-bit luma output.
// Depends on ndg_pkg, ndg_pos, ndg_luma and nearest_neighbor_downscale_gray_macros.svh.
//
// The block takes one source pixel item in every clock cycle unless m_tready stalls the
// output. The rate is set by the two-stage register pipeline: the position tracker
// selects and updates its counters in the cycle an item is accepted, and the output
// stage converts and registers the result. Source items that select no destination
// pixel produce nothing. Sizes are clamped so that only downscaling occurs, and a frame
// start on tuser realigns all positions. There is no clearing pass after reset. The user
// must write configuration only while the block is idle; the block does not enforce it.
`include "nearest_neighbor_downscale_gray_macros.svh"

module nearest_neighbor_downscale_gray
    import ndg_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,   // pixel_in[15:0]
    input  logic               s_tuser,   // frame_start
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // dst_x[10:0], dst_y[21:11], pixel_out[37:22], zero
    output logic               m_tlast
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [CFG_W-1:0] src_width_reg;
    logic [CFG_W-1:0] src_height_reg;
    logic [CFG_W-1:0] dst_width_reg;
    logic [CFG_W-1:0] dst_height_reg;
    logic             gray_mode_reg;

    logic [DIM_W-1:0] sw, sh, dw, dh;
    logic             accept;
    logic             adv;
    logic             sel_valid;
    sel_item_t        sel_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_WIDTH_RST;
            src_height_reg <= SRC_HEIGHT_RST;
            dst_width_reg  <= DST_WIDTH_RST;
            dst_height_reg <= DST_HEIGHT_RST;
            gray_mode_reg  <= GRAY_MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                REG_GRAY_MODE:  gray_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Source sizes are held to 1..MAX_DIM, destination sizes to 1..source size.
    assign sw = (src_width_reg == '0) ? DIM_W'(1)
              : (32'(src_width_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
              : DIM_W'(src_width_reg);
    assign sh = (src_height_reg == '0) ? DIM_W'(1)
              : (32'(src_height_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
              : DIM_W'(src_height_reg);
    assign dw = (dst_width_reg == '0) ? DIM_W'(1)
              : (32'(dst_width_reg) > 32'(sw)) ? sw
              : DIM_W'(dst_width_reg);
    assign dh = (dst_height_reg == '0) ? DIM_W'(1)
              : (32'(dst_height_reg) > 32'(sh)) ? sh
              : DIM_W'(dst_height_reg);

    assign s_tready = !sel_valid || adv;
    assign accept   = s_tvalid && s_tready;

    ndg_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (s_tdata),
        .frame_start (s_tuser),
        .sw          (sw),
        .sh          (sh),
        .dw          (dw),
        .dh          (dh),
        .adv         (adv),
        .sel_valid   (sel_valid),
        .sel_item    (sel_item)
    );

    ndg_luma u_luma (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel_valid (sel_valid),
        .sel_item  (sel_item),
        .gray_mode (gray_mode_reg),
        .m_tready  (m_tready),
        .adv       (adv),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A frame start item always selects destination pixel (0,0).
    `NDG_ASSERT_NEXT(a_fs_origin, accept && s_tuser, sel_valid && ({sel_item.x, sel_item.y} == '0))
    // A selected item waiting on a stalled output stage is neither lost nor altered.
    `NDG_ASSERT_NEXT(a_stage_hold, sel_valid && !adv, sel_valid && $stable(sel_item))
    // No item is taken while the selection stage is occupied and cannot move on.
    `NDG_ASSERT_NOW(a_no_overrun, sel_valid && m_tvalid && !m_tready, !accept)

endmodule
